>>> rtl/core/fgki_pkg.sv
package fgki_pkg;

   localparam logic       CMD_LABEL  = 1'b0;
   localparam logic       CMD_KEY    = 1'b1;

   localparam logic [1:0] KIND_LABEL = 2'd0;
   localparam logic [1:0] KIND_ID    = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   localparam logic [7:0] THRESHOLD_RESET = 8'd1;
   localparam logic [8:0] COUNT_MAX       = 9'd511;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic        line_last;
      logic [63:0] value;
   } item_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [1:0]  result_kind;
      logic        line_end;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic        vld;
      logic [63:0] key;
      logic [8:0]  cnt;
      logic [63:0] id;
   } entry_type;

endpackage

>>> rtl/core/fgki_ram.sv
module fgki_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/fgki_front.sv
module fgki_front import fgki_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024,
   localparam int AW = $clog2(TABLE_ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  item_type      req_item,
   output logic          push_valid,
   input  logic          push_ready,
   output item_type      push_item,
   output logic [AW-1:0] push_hash
);

   localparam logic [AW:0] N_L = (AW+1)'(TABLE_ENTRIES);

   logic          vld_ff, vld_in;
   item_type      item_ff;
   logic [AW-1:0] hash_ff;
   logic [AW-1:0] fold;
   logic [AW:0]   fold_x;
   logic          accept;

   // xor-fold of the key, then one subtract brings it into the table range
   always_comb begin
      fold = '0;
      for (int j = 0; j < 64; j++) begin
         fold[j % AW] = fold[j % AW] ^ req_item.value[j];
      end
      fold_x = {1'b0, fold};
      if (fold_x >= N_L) begin
         fold_x = fold_x - N_L;
      end
   end

   assign req_ready = !vld_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         item_ff <= req_item;
         hash_ff <= fold_x[AW-1:0];
      end
   end

   assign push_valid = vld_ff;
   assign push_item  = item_ff;
   assign push_hash  = hash_ff;

endmodule

>>> rtl/core/fgki_queue.sv
module fgki_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = data_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         data_ff[wr_ff] <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |=> cnt_ff == 2'd2)
      else $error("queue lost or gained a word while full");
`endif

endmodule

>>> rtl/core/fgki_back.sv
module fgki_back import fgki_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024,
   localparam int AW = $clog2(TABLE_ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    threshold,
   input  logic          q_valid,
   output logic          q_pop,
   input  item_type      q_item,
   input  logic [AW-1:0] q_hash,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp
);

   localparam logic [AW:0]   N_L  = (AW+1)'(TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
   localparam int            EW   = $bits(entry_type);

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   item_type      cur_ff, cur_in;
   logic [AW-1:0] probe_ff, probe_in;
   logic [AW:0]   tries_ff, tries_in;
   logic [63:0]   next_id_ff, next_id_in;
   rsp_type       res_ff, res_in;
   logic          out_vld_ff, out_vld_in;
   rsp_type       out_ff, out_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata;
   logic [EW-1:0] ram_rdata;
   entry_type     rd_entry;

   logic          hit, empty, exhausted, out_free;
   logic [AW-1:0] probe_next;
   logic [8:0]    lim;

   fgki_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rd_entry   = entry_type'(ram_rdata);
      hit        = rd_entry.vld && (rd_entry.key == cur_ff.value);
      empty      = !rd_entry.vld;
      exhausted  = (tries_ff == N_L - 1'b1);
      probe_next = (probe_ff == LAST) ? '0 : probe_ff + 1'b1;
      out_free   = !out_vld_ff || rsp_ready;
      lim        = {1'b0, threshold} + 9'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == LAST) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_item.cmd == CMD_KEY) ? ST_PROBE : ST_DONE;
            end
         end
         ST_PROBE: if (hit || empty || exhausted) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and table access
   always_comb begin
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      probe_in   = probe_ff;
      tries_in   = tries_ff;
      next_id_in = next_id_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = probe_ff;
      ram_wdata  = rd_entry;
      ram_raddr  = probe_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            ram_raddr = q_hash;
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               probe_in = q_hash;
               tries_in = '0;
               res_in   = '{result_value: q_item.value, result_kind: KIND_LABEL,
                            line_end: q_item.line_last, table_full: 1'b0};
            end
         end
         ST_PROBE: begin
            ram_raddr = probe_next;
            res_in    = '{result_value: 64'd0, result_kind: KIND_NONE,
                          line_end: cur_ff.line_last, table_full: 1'b0};
            if (hit) begin
               if (rd_entry.cnt == lim) begin
                  ram_we                = 1'b1;
                  ram_wdata.id          = next_id_ff;
                  ram_wdata.cnt         = rd_entry.cnt + 9'd1;
                  res_in.result_value   = next_id_ff;
                  res_in.result_kind    = KIND_ID;
                  next_id_in            = next_id_ff + 64'd1;
               end else if (rd_entry.cnt > lim) begin
                  res_in.result_value   = rd_entry.id;
                  res_in.result_kind    = KIND_ID;
               end else if (rd_entry.cnt < COUNT_MAX) begin
                  ram_we                = 1'b1;
                  ram_wdata.cnt         = rd_entry.cnt + 9'd1;
               end
            end else if (empty) begin
               ram_we    = 1'b1;
               ram_wdata = '{vld: 1'b1, key: cur_ff.value, cnt: 9'd1, id: 64'd0};
            end else if (exhausted) begin
               res_in.table_full = 1'b1;
            end else begin
               probe_in = probe_next;
               tries_in = tries_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in     = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         next_id_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         next_id_ff <= next_id_in;
         out_vld_ff <= out_vld_in;
      end
      cur_ff   <= cur_in;
      probe_ff <= probe_in;
      tries_ff <= tries_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = out_ff;

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("queue popped outside idle");
   a_probe_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE && !hit && !empty && !exhausted
      |=> state_ff == ST_PROBE && tries_ff == $past(tries_ff) + 1'b1)
      else $error("probe did not advance");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !out_vld_ff && !q_pop)
      else $error("activity during clearing pass");
   a_tries_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> tries_ff < N_L)
      else $error("probe count past table size");
`endif

endmodule

>>> rtl/core/frequency_gated_key_indexer_unit.sv
// frequency gated key indexer
// req_ channel takes one word per item: req_cmd selects a line label (passed
// through) or a 64-bit feature key (req_value); req_line_last marks end of line.
// rsp_ channel gives exactly one word per item, in order: the label or the
// dense id, a kind code (label, id, nothing), the line end flag and a flag
// for a new key that found the table full.
// csr_ channel writes the count threshold; write it only while the block
// is empty. csr_ready is always high.
// keys sit in a hashed table with linear probing, one probe a cycle from a
// single registered-read ram; an item passes the input stage, a two-word
// queue, the idle state, the probe state (keys only), the done state and
// the output register.
// the back works on one item at a time and pops the next one from idle.
// the front keeps accepting into the queue while the back works.
// after reset the back runs a clearing pass over every ram entry; words are
// queued meanwhile but not processed.
// a stalled rsp_ready holds the result; once the queue and the input stage fill, req_ready drops.
module frequency_gated_key_indexer_unit import fgki_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_value,
   input  logic        req_line_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_value,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_line_end,
   output logic        rsp_table_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_count_threshold
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int QW = $bits(item_type) + AW;

   logic [7:0]    thr_ff;
   item_type      req_item, push_item, q_item;
   logic [AW-1:0] push_hash, q_hash;
   logic          push_valid, push_ready, q_valid, q_pop;
   logic [QW-1:0] q_data;
   rsp_type       rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_count_threshold;
      end
   end

   assign req_item = '{cmd: req_cmd, line_last: req_line_last, value: req_value};

   fgki_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .push_hash  (push_hash)
   );

   fgki_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_item, push_hash}),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_data)
   );

   assign q_item = item_type'(q_data[QW-1:AW]);
   assign q_hash = q_data[AW-1:0];

   fgki_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (thr_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .q_hash    (q_hash),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_result_value = rsp.result_value;
   assign rsp_result_kind  = rsp.result_kind;
   assign rsp_line_end     = rsp.line_end;
   assign rsp_table_full   = rsp.table_full;

endmodule

>>> dv/tb_frequency_gated_key_indexer_unit.sv
`timescale 1ns / 1ps

module tb_frequency_gated_key_indexer_unit;
   import fgki_pkg::*;

   localparam int SLOTS       = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int TAIL_CYCLES = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_LABEL;
   logic [63:0] req_value = '0;
   logic        req_line_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_result_value;
   logic [1:0]  rsp_result_kind;
   logic        rsp_line_end;
   logic        rsp_table_full;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_count_threshold = '0;

   frequency_gated_key_indexer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_value(req_value), .req_line_last(req_line_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_result_kind(rsp_result_kind),
      .rsp_line_end(rsp_line_end), .rsp_table_full(rsp_table_full),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_count_threshold(csr_count_threshold)
   );

   always #2 clock = ~clock;

   // mirror of the key table
   logic [8:0]  key_count [logic [63:0]];
   logic [63:0] key_id [logic [63:0]];
   logic [63:0] keys_seen [$];
   int          slots_used = 0;
   logic [63:0] next_dense_id = '0;
   logic [7:0]  threshold = THRESHOLD_RESET;

   item_type    pending_words [$];
   rsp_type     expected_rsps [$];
   int          errors = 0;
   int          cycles = 0;
   int          send_idle = 0;
   int          recv_stall = 0;
   int          holdoff_req = 0;
   int          holdoff_seen = 0;
   int          holdoff_left = 0;

   function automatic void index_word(item_type w);
      rsp_type    r;
      logic [8:0] lim;
      logic [8:0] c;
      r.result_value = '0;
      r.result_kind  = KIND_NONE;
      r.line_end     = w.line_last;
      r.table_full   = 1'b0;
      lim = {1'b0, threshold} + 9'd1;
      if (w.cmd == CMD_LABEL) begin
         r.result_value = w.value;
         r.result_kind  = KIND_LABEL;
      end else if (!key_count.exists(w.value)) begin
         if (slots_used < SLOTS) begin
            key_count[w.value] = 9'd1;
            key_id[w.value]    = '0;
            slots_used++;
         end else begin
            r.table_full = 1'b1;
         end
      end else begin
         c = key_count[w.value];
         if (c == lim) begin
            key_id[w.value] = next_dense_id;
            r.result_value  = next_dense_id;
            r.result_kind   = KIND_ID;
            next_dense_id++;
            if (c < COUNT_MAX) key_count[w.value] = c + 9'd1;
         end else if (c > lim) begin
            r.result_value = key_id[w.value];
            r.result_kind  = KIND_ID;
         end else if (c < COUNT_MAX) begin
            key_count[w.value] = c + 9'd1;
         end
      end
      expected_rsps = {expected_rsps, r};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            index_word(pending_words[0]);
            void'(pending_words.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_valid     <= 1'b1;
               req_cmd       <= pending_words[0].cmd;
               req_value     <= pending_words[0].value;
               req_line_last <= pending_words[0].line_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (holdoff_req != holdoff_seen) begin
         holdoff_seen <= holdoff_req;
         holdoff_left <= 400;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected word value=%h kind=%0d", $time,
                     rsp_result_value, rsp_result_kind);
            errors++;
         end else begin
            if (rsp_result_value !== expected_rsps[0].result_value) begin
               $display("%0t: result_value expected %h actual %h", $time,
                        expected_rsps[0].result_value, rsp_result_value);
               errors++;
            end
            if (rsp_result_kind !== expected_rsps[0].result_kind) begin
               $display("%0t: result_kind expected %0d actual %0d", $time,
                        expected_rsps[0].result_kind, rsp_result_kind);
               errors++;
            end
            if (rsp_line_end !== expected_rsps[0].line_end) begin
               $display("%0t: line_end expected %0d actual %0d", $time,
                        expected_rsps[0].line_end, rsp_line_end);
               errors++;
            end
            if (rsp_table_full !== expected_rsps[0].table_full) begin
               $display("%0t: table_full expected %0d actual %0d", $time,
                        expected_rsps[0].table_full, rsp_table_full);
               errors++;
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("frequency_gated_key_indexer_unit test failed");
         $finish;
      end
   end

   task automatic push_word(input logic cmd, input logic [63:0] value, input logic last);
      item_type w;
      w.cmd = cmd;
      w.value = value;
      w.line_last = last;
      pending_words = {pending_words, w};
      if (cmd == CMD_KEY) keys_seen = {keys_seen, value};
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_count_threshold <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold = v;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_words(input int n, input int pool_size);
      logic [63:0] pool [$];
      int          i;
      for (i = 0; i < pool_size; i++) begin
         if (keys_seen.size() != 0 && $urandom_range(2) == 0)
            pool = {pool, keys_seen[$urandom_range(keys_seen.size() - 1)]};
         else
            pool = {pool, rand64()};
      end
      for (i = 0; i < n; i++) begin
         if ($urandom_range(99) < 15)
            push_word(CMD_LABEL, rand64(), 1'($urandom_range(1)));
         else
            push_word(CMD_KEY, pool[$urandom_range(pool_size - 1)],
                      1'($urandom_range(1)));
      end
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 59; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 59; end
         default: begin send_idle = 33; recv_stall = 33; end
      endcase
   endtask

   int          p;
   int          k;
   logic [63:0] fresh;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // labels at the extremes, then keys walking through the reset threshold
      push_word(CMD_LABEL, 64'd0, 1'b0);
      push_word(CMD_LABEL, '1, 1'b1);
      push_word(CMD_LABEL, 64'h5555_5555_5555_5555, 1'b0);
      for (k = 0; k < 4; k++) push_word(CMD_KEY, 64'd0, k[0]);
      for (k = 0; k < 4; k++) push_word(CMD_KEY, '1, ~k[0]);
      push_word(CMD_LABEL, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      drain();

      // lowest threshold: second sight earns an id
      write_threshold(8'd0);
      for (k = 0; k < 3; k++) push_word(CMD_KEY, 64'h8000_0000_0000_0001, 1'b0);
      push_word(CMD_KEY, 64'd0, 1'b1);
      drain();

      // highest threshold: one hot key walks the whole count
      write_threshold(8'd255);
      set_idling(1);
      for (k = 0; k < 259; k++) push_word(CMD_KEY, 64'h0123_4567_89AB_CDEF, k[0]);
      random_words(40, 6);
      drain();

      for (p = 0; p < 8; p++) begin
         write_threshold(p == 3 ? 8'd1 : 8'($urandom_range(p[0] ? 6 : 2)));
         set_idling(p);
         if (p == 4) holdoff_req++;
         random_words(55, 4 + $urandom_range(20));
         if (p == 5) begin
            drain();
            random_words(30, 5);
         end
         drain();
      end

      // fill the table with fresh keys, then push beyond it
      write_threshold(8'd2);
      set_idling(3);
      while (slots_used + pending_words.size() < SLOTS) begin
         fresh = rand64();
         if (!key_count.exists(fresh)) push_word(CMD_KEY, fresh, 1'($urandom_range(1)));
         if (pending_words.size() > 64) drain();
      end
      drain();
      for (k = 0; k < 40; k++) begin
         if (k % 3 == 0)
            push_word(CMD_KEY, rand64(), 1'($urandom_range(1)));
         else
            push_word(CMD_KEY, keys_seen[$urandom_range(keys_seen.size() - 1)],
                      1'($urandom_range(1)));
      end
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("frequency_gated_key_indexer_unit test passed");
      end else begin
         if (expected_rsps.size() != 0)
            $display("%0t: %0d words never arrived", $time, expected_rsps.size());
         $display("frequency_gated_key_indexer_unit test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/fgki_pkg.sv
rtl/core/fgki_ram.sv
rtl/core/fgki_front.sv
rtl/core/fgki_queue.sv
rtl/core/fgki_back.sv
rtl/core/frequency_gated_key_indexer_unit.sv
dv/tb_frequency_gated_key_indexer_unit.sv
